[rtl/mlbc_pkg.sv]
// Shared types and codes for the multi-lamp blink controller.
// No dependencies; used by every module in rtl/.
`default_nettype none
package mlbc_pkg;

    localparam int OP_W   = 2;
    localparam int ID_W   = 3;
    localparam int MODE_W = 2;
    localparam int MS_W   = 16;
    localparam int REPS_W = 8;

    localparam logic [OP_W-1:0] OP_SET  = 2'd0;
    localparam logic [OP_W-1:0] OP_OFF  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ON    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BLINK = 2'd2;

    localparam logic [REPS_W-1:0] REPS_ENDLESS = 8'hFF;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture item fields, point at lamp_id
        logic idx_clear;  // point at lamp 0 instead
        logic div_go;     // start ms -> tick conversion
        logic set_wr;     // write set result into addressed lamp
        logic off_one;    // switch addressed lamp off
        logic tick_one;   // advance addressed lamp by one tick
        logic idx_inc;
        logic emit;       // compare pattern, send if changed
    } mlbc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic idx_last;
        logic id_ok;
    } mlbc_sts_t;

endpackage
`default_nettype wire

[rtl/mlbc_div.sv]
// Two-lane divider by the constant TICK_MS using a reciprocal multiply.
// Quotients and done are registered when go is high. Depends on mlbc_pkg.
`default_nettype none
module mlbc_div #(
    parameter int TICK_MS = 10
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       go,
    input  wire [mlbc_pkg::MS_W-1:0]  dividend_a,
    input  wire [mlbc_pkg::MS_W-1:0]  dividend_b,
    output logic [mlbc_pkg::MS_W-1:0] quot_a,
    output logic [mlbc_pkg::MS_W-1:0] quot_b,
    output logic                      done
);
    localparam int MS_W    = mlbc_pkg::MS_W;
    localparam int SHIFT   = MS_W + $clog2(TICK_MS);
    localparam int RECIP_W = MS_W + 1;
    localparam int PROD_W  = MS_W + RECIP_W;
    // ceil(2^SHIFT / TICK_MS) is exact for every MS_W-bit dividend
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(TICK_MS - 1)) / 64'(TICK_MS));

    logic [PROD_W-1:0] prod_a, prod_b;
    logic [MS_W-1:0]   qa_reg, qb_reg;
    logic              done_reg;

    assign prod_a = PROD_W'(dividend_a) * PROD_W'(RECIP);
    assign prod_b = PROD_W'(dividend_b) * PROD_W'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            qa_reg <= MS_W'(prod_a >> SHIFT);
            qb_reg <= MS_W'(prod_b >> SHIFT);
        end
    end

    assign quot_a = qa_reg;
    assign quot_b = qb_reg;
    assign done   = done_reg;

endmodule
`default_nettype wire

[rtl/mlbc_dp.sv]
// Datapath: per-lamp state registers, one-lamp update logic, display pattern.
// Depends on mlbc_pkg and mlbc_div.
`default_nettype none
module mlbc_dp #(
    parameter int LAMPS   = 6,
    parameter int TICK_MS = 10
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  mlbc_pkg::mlbc_cmd_t          cmd,
    output mlbc_pkg::mlbc_sts_t          sts,
    input  wire [mlbc_pkg::ID_W-1:0]     lamp_id,
    input  wire [mlbc_pkg::MODE_W-1:0]   mode,
    input  wire [mlbc_pkg::MS_W-1:0]     on_ms,
    input  wire [mlbc_pkg::MS_W-1:0]     off_ms,
    input  wire [mlbc_pkg::REPS_W-1:0]   repeat_count,
    input  wire                          exclusive,
    output logic [LAMPS-1:0]             display_bits,
    output logic                         result_valid
);
    localparam int MS_W   = mlbc_pkg::MS_W;
    localparam int MODE_W = mlbc_pkg::MODE_W;
    localparam int REPS_W = mlbc_pkg::REPS_W;
    localparam int IDX_W  = (LAMPS > 1) ? $clog2(LAMPS) : 1;
    localparam int CNT_W  = $clog2(((1 << MS_W) - 1) / TICK_MS + 1);

    // per-lamp state
    logic [MODE_W-1:0] lamp_mode_reg [LAMPS];
    logic              lamp_lit_reg  [LAMPS];
    logic [CNT_W-1:0]  on_rem_reg    [LAMPS];
    logic [CNT_W-1:0]  off_rem_reg   [LAMPS];
    logic [CNT_W-1:0]  on_rel_reg    [LAMPS];
    logic [CNT_W-1:0]  off_rel_reg   [LAMPS];
    logic [REPS_W-1:0] cyc_reg       [LAMPS];

    logic [LAMPS-1:0]  display_now_reg, display_now_next;
    logic [LAMPS-1:0]  display_sent_reg;
    logic [LAMPS-1:0]  out_reg;
    logic              strobe_reg;
    logic [IDX_W-1:0]  idx_reg;

    // captured item fields
    logic [MODE_W-1:0] mode_in_reg;
    logic [REPS_W-1:0] reps_in_reg;
    logic              excl_in_reg;

    logic [MODE_W-1:0] mode_next;
    logic              lit_next;
    logic [CNT_W-1:0]  on_rem_next, off_rem_next, on_rel_next, off_rel_next;
    logic [REPS_W-1:0] cyc_next;
    logic [LAMPS-1:0]  lamp_bit;
    logic              lamp_wr;

    logic [MS_W-1:0]   quot_on, quot_off;
    logic              div_done;

    mlbc_div #(.TICK_MS(TICK_MS)) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (cmd.div_go),
        .dividend_a (on_ms),
        .dividend_b (off_ms),
        .quot_a     (quot_on),
        .quot_b     (quot_off),
        .done       (div_done)
    );

    assign lamp_bit = LAMPS'(1) << idx_reg;
    assign lamp_wr  = cmd.set_wr | cmd.off_one | cmd.tick_one;

    always_comb
    begin
        mode_next        = lamp_mode_reg[idx_reg];
        lit_next         = lamp_lit_reg[idx_reg];
        on_rem_next      = on_rem_reg[idx_reg];
        off_rem_next     = off_rem_reg[idx_reg];
        on_rel_next      = on_rel_reg[idx_reg];
        off_rel_next     = off_rel_reg[idx_reg];
        cyc_next         = cyc_reg[idx_reg];
        display_now_next = display_now_reg;

        if (cmd.set_wr)
        begin
            mode_next    = (mode_in_reg == mlbc_pkg::MODE_ON ||
                            mode_in_reg == mlbc_pkg::MODE_BLINK) ? mode_in_reg
                                                                 : mlbc_pkg::MODE_OFF;
            on_rem_next  = '0;
            off_rem_next = '0;
            on_rel_next  = CNT_W'(quot_on);
            off_rel_next = CNT_W'(quot_off);
            cyc_next     = reps_in_reg;
            if (excl_in_reg)
                display_now_next = lamp_bit;
            else if (mode_next == mlbc_pkg::MODE_OFF)
                display_now_next = display_now_reg & ~lamp_bit;
            else
                display_now_next = display_now_reg | lamp_bit;
        end
        else if (cmd.off_one)
        begin
            if (mode_next != mlbc_pkg::MODE_OFF)
            begin
                mode_next        = mlbc_pkg::MODE_OFF;
                on_rem_next      = '0;
                off_rem_next     = '0;
                on_rel_next      = '0;
                off_rel_next     = '0;
                cyc_next         = '0;
                display_now_next = display_now_reg & ~lamp_bit;
            end
        end
        else if (cmd.tick_one)
        begin
            case (mode_next)
                mlbc_pkg::MODE_BLINK:
                begin
                    if (cyc_next == '0)
                    begin
                        mode_next = mlbc_pkg::MODE_OFF;
                    end
                    else
                    begin
                        if (!lit_next)
                        begin
                            if (off_rem_next == '0)
                            begin
                                display_now_next = display_now_reg | lamp_bit;
                                on_rem_next      = on_rel_next;
                                lit_next         = 1'b1;
                            end
                        end
                        else if (on_rem_next == '0)
                        begin
                            display_now_next = display_now_reg & ~lamp_bit;
                            off_rem_next     = off_rel_next;
                            lit_next         = 1'b0;
                            if (cyc_next != mlbc_pkg::REPS_ENDLESS)
                                cyc_next = cyc_next - 1'b1;
                        end
                        if (on_rem_next != '0)
                            on_rem_next = on_rem_next - 1'b1;
                        if (off_rem_next != '0)
                            off_rem_next = off_rem_next - 1'b1;
                    end
                end
                mlbc_pkg::MODE_ON:
                begin
                    if (!lit_next)
                    begin
                        display_now_next = display_now_reg | lamp_bit;
                        lit_next         = 1'b1;
                    end
                end
                default:
                begin
                    if (lit_next)
                    begin
                        display_now_next = display_now_reg & ~lamp_bit;
                        lit_next         = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAMPS; i++)
            begin
                lamp_mode_reg[i] <= mlbc_pkg::MODE_OFF;
                lamp_lit_reg[i]  <= 1'b0;
                on_rem_reg[i]    <= '0;
                off_rem_reg[i]   <= '0;
                on_rel_reg[i]    <= '0;
                off_rel_reg[i]   <= '0;
                cyc_reg[i]       <= '0;
            end
            display_now_reg  <= '0;
            display_sent_reg <= '0;
            strobe_reg       <= 1'b0;
            idx_reg          <= '0;
        end
        else
        begin
            if (lamp_wr)
            begin
                lamp_mode_reg[idx_reg] <= mode_next;
                lamp_lit_reg[idx_reg]  <= lit_next;
                on_rem_reg[idx_reg]    <= on_rem_next;
                off_rem_reg[idx_reg]   <= off_rem_next;
                on_rel_reg[idx_reg]    <= on_rel_next;
                off_rel_reg[idx_reg]   <= off_rel_next;
                cyc_reg[idx_reg]       <= cyc_next;
            end
            display_now_reg <= display_now_next;

            if (cmd.load)
                idx_reg <= cmd.idx_clear ? '0 : IDX_W'(lamp_id);
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;

            strobe_reg <= 1'b0;
            if (cmd.emit && display_now_reg != display_sent_reg)
            begin
                display_sent_reg <= display_now_reg;
                strobe_reg       <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_in_reg <= mode;
            reps_in_reg <= repeat_count;
            excl_in_reg <= exclusive;
        end
        if (cmd.emit)
            out_reg <= display_now_reg;
    end

    always_comb
    begin
        sts.div_done = div_done;
        sts.idx_last = idx_reg == IDX_W'(LAMPS - 1);
        sts.id_ok    = {1'b0, lamp_id} < (mlbc_pkg::ID_W+1)'(LAMPS);
    end

    assign display_bits = out_reg;
    assign result_valid = strobe_reg;

endmodule
`default_nettype wire

[rtl/mlbc_ctrl.sv]
// Controller: decodes an accepted item and sequences the datapath over lamps.
// Depends on mlbc_pkg.
`default_nettype none
module mlbc_ctrl (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire [mlbc_pkg::OP_W-1:0]    operation,
    input  wire                         all_lamps,
    input  mlbc_pkg::mlbc_sts_t         sts,
    output mlbc_pkg::mlbc_cmd_t         cmd,
    output logic                        busy
);
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_OFF,
        ST_TICK,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   all_reg, all_next;
    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = state_reg != ST_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        all_next   = all_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        mlbc_pkg::OP_SET:
                        begin
                            if (sts.id_ok)
                            begin
                                cmd.load   = 1'b1;
                                cmd.div_go = 1'b1;
                                state_next = ST_DIVIDE;
                            end
                        end
                        mlbc_pkg::OP_OFF:
                        begin
                            all_next = all_lamps;
                            if (all_lamps)
                            begin
                                cmd.load      = 1'b1;
                                cmd.idx_clear = 1'b1;
                                state_next    = ST_OFF;
                            end
                            else if (sts.id_ok)
                            begin
                                cmd.load   = 1'b1;
                                state_next = ST_OFF;
                            end
                        end
                        mlbc_pkg::OP_TICK:
                        begin
                            cmd.load      = 1'b1;
                            cmd.idx_clear = 1'b1;
                            state_next    = ST_TICK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIVIDE:
            begin
                if (sts.div_done)
                begin
                    cmd.set_wr = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_OFF:
            begin
                cmd.off_one = 1'b1;
                if (!all_reg || sts.idx_last)
                    state_next = ST_IDLE;
                else
                    cmd.idx_inc = 1'b1;
            end
            ST_TICK:
            begin
                cmd.tick_one = 1'b1;
                if (sts.idx_last)
                    state_next = ST_EMIT;
                else
                    cmd.idx_inc = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            all_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            all_reg   <= all_next;
        end
    end

endmodule
`default_nettype wire

[rtl/multi_lamp_blink_controller.sv]
// Top level of the multi-lamp blink controller: controller plus datapath.
// Depends on mlbc_pkg, mlbc_ctrl, mlbc_dp (which holds mlbc_div).
//
// An item is taken when start is high and busy is low; busy stays high until
// the block can take the next one. A tick walks the lamps one per cycle and
// then compares the pattern; if the pattern changed, display_bits carries it
// with result_valid high for one cycle right after that, and it must be
// captured then, since the receiver cannot stall. A set converts both times
// by TICK_MS with a reciprocal multiply registered at acceptance and then
// writes the lamp. An off of one lamp clears that lamp; an off of every lamp
// walks all the lamps in turn. Set and off items and items with an unused
// operation code give no result.
`default_nettype none
module multi_lamp_blink_controller #(
    parameter int LAMPS   = 6,
    parameter int TICK_MS = 10
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire [mlbc_pkg::OP_W-1:0]     operation,
    input  wire [mlbc_pkg::ID_W-1:0]     lamp_id,
    input  wire                          all_lamps,
    input  wire [mlbc_pkg::MODE_W-1:0]   mode,
    input  wire [mlbc_pkg::MS_W-1:0]     on_ms,
    input  wire [mlbc_pkg::MS_W-1:0]     off_ms,
    input  wire [mlbc_pkg::REPS_W-1:0]   repeat_count,
    input  wire                          exclusive,
    output logic                         result_valid,
    output logic [LAMPS-1:0]             display_bits
);
    mlbc_pkg::mlbc_cmd_t cmd;
    mlbc_pkg::mlbc_sts_t sts;

    mlbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .all_lamps (all_lamps),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    mlbc_dp #(
        .LAMPS   (LAMPS),
        .TICK_MS (TICK_MS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .lamp_id      (lamp_id),
        .mode         (mode),
        .on_ms        (on_ms),
        .off_ms       (off_ms),
        .repeat_count (repeat_count),
        .exclusive    (exclusive),
        .display_bits (display_bits),
        .result_valid (result_valid)
    );

endmodule
`default_nettype wire

[sim/tb_multi_lamp_blink_controller.sv]
// Testbench for multi_lamp_blink_controller: directed and random lamp items
// checked against a cycle-free model of the lamp pattern. Needs mlbc_pkg and
// the RTL in rtl/.
module tb_multi_lamp_blink_controller;

    localparam int LAMPS      = 6;
    localparam int TICK_MS    = 10;
    localparam int RAND_ITEMS = 750;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYC  = 40;

    localparam int OP_W   = mlbc_pkg::OP_W;
    localparam int ID_W   = mlbc_pkg::ID_W;
    localparam int MODE_W = mlbc_pkg::MODE_W;
    localparam int MS_W   = mlbc_pkg::MS_W;
    localparam int REPS_W = mlbc_pkg::REPS_W;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic              all;
        logic [MODE_W-1:0] md;
        logic [MS_W-1:0]   on_t;
        logic [MS_W-1:0]   off_t;
        logic [REPS_W-1:0] reps;
        logic              excl;
        bit                hold;   // pause marker, not sent to the block
    } lamp_item_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              start        = 1'b0;
    logic [OP_W-1:0]   operation    = '0;
    logic [ID_W-1:0]   lamp_id      = '0;
    logic              all_lamps    = 1'b0;
    logic [MODE_W-1:0] mode         = '0;
    logic [MS_W-1:0]   on_ms        = '0;
    logic [MS_W-1:0]   off_ms       = '0;
    logic [REPS_W-1:0] repeat_count = '0;
    logic              exclusive    = 1'b0;
    logic              busy;
    logic              result_valid;
    logic [LAMPS-1:0]  display_bits;

    multi_lamp_blink_controller #(
        .LAMPS   (LAMPS),
        .TICK_MS (TICK_MS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .lamp_id      (lamp_id),
        .all_lamps    (all_lamps),
        .mode         (mode),
        .on_ms        (on_ms),
        .off_ms       (off_ms),
        .repeat_count (repeat_count),
        .exclusive    (exclusive),
        .result_valid (result_valid),
        .display_bits (display_bits)
    );

    always #1 clk = ~clk;

    // lamp model state
    logic [MODE_W-1:0] lamp_md     [LAMPS];
    logic              lamp_on     [LAMPS];
    logic [12:0]       lit_left    [LAMPS];
    logic [12:0]       dark_left   [LAMPS];
    logic [12:0]       lit_len     [LAMPS];
    logic [12:0]       dark_len    [LAMPS];
    logic [REPS_W-1:0] blinks_left [LAMPS];
    logic [LAMPS-1:0]  pattern_now;
    logic [LAMPS-1:0]  pattern_sent;

    lamp_item_t       pending_items[$];
    logic [LAMPS-1:0] expected_patterns[$];
    int               errors = 0;

    // Apply one accepted item to the lamp model; queue the pattern a tick emits.
    function automatic void predict_item(input lamp_item_t it);
        int k;
        logic [MODE_W-1:0] m;
        if (it.op == mlbc_pkg::OP_SET)
        begin
            if (it.id < LAMPS)
            begin
                m = (it.md > mlbc_pkg::MODE_BLINK) ? mlbc_pkg::MODE_OFF : it.md;
                lamp_md[it.id]     = m;
                lit_left[it.id]    = '0;
                dark_left[it.id]   = '0;
                lit_len[it.id]     = 13'(it.on_t / TICK_MS);
                dark_len[it.id]    = 13'(it.off_t / TICK_MS);
                blinks_left[it.id] = it.reps;
                if (it.excl)
                    pattern_now = LAMPS'(1 << it.id);
                else
                    pattern_now[it.id] = (m != mlbc_pkg::MODE_OFF);
            end
        end
        else if (it.op == mlbc_pkg::OP_OFF)
        begin
            for (k = 0; k < LAMPS; k++)
            begin
                if ((it.all || k == it.id) && lamp_md[k] != mlbc_pkg::MODE_OFF)
                begin
                    lamp_md[k]     = mlbc_pkg::MODE_OFF;
                    lit_left[k]    = '0;
                    dark_left[k]   = '0;
                    lit_len[k]     = '0;
                    dark_len[k]    = '0;
                    blinks_left[k] = '0;
                    pattern_now[k] = 1'b0;
                end
            end
        end
        else if (it.op == mlbc_pkg::OP_TICK)
        begin
            for (k = 0; k < LAMPS; k++)
            begin
                if (lamp_md[k] == mlbc_pkg::MODE_BLINK)
                begin
                    if (blinks_left[k] == 0)
                    begin
                        lamp_md[k] = mlbc_pkg::MODE_OFF;
                    end
                    else
                    begin
                        if (!lamp_on[k])
                        begin
                            if (dark_left[k] == 0)
                            begin
                                pattern_now[k] = 1'b1;
                                lit_left[k]    = lit_len[k];
                                lamp_on[k]     = 1'b1;
                            end
                        end
                        else if (lit_left[k] == 0)
                        begin
                            pattern_now[k] = 1'b0;
                            dark_left[k]   = dark_len[k];
                            lamp_on[k]     = 1'b0;
                            if (blinks_left[k] != mlbc_pkg::REPS_ENDLESS)
                                blinks_left[k] = blinks_left[k] - 1'b1;
                        end
                        if (lit_left[k] != 0) lit_left[k] = lit_left[k] - 1'b1;
                        if (dark_left[k] != 0) dark_left[k] = dark_left[k] - 1'b1;
                    end
                end
                else if (lamp_md[k] == mlbc_pkg::MODE_ON)
                begin
                    if (!lamp_on[k])
                    begin
                        pattern_now[k] = 1'b1;
                        lamp_on[k]     = 1'b1;
                    end
                end
                else if (lamp_on[k])
                begin
                    pattern_now[k] = 1'b0;
                    lamp_on[k]     = 1'b0;
                end
            end
            if (pattern_now != pattern_sent)
            begin
                pattern_sent = pattern_now;
                expected_patterns.push_back(pattern_now);
            end
        end
    endfunction

    function automatic lamp_item_t make_item(input logic [OP_W-1:0] op,
                                             input logic [ID_W-1:0] id,
                                             input logic all,
                                             input logic [MODE_W-1:0] md,
                                             input logic [MS_W-1:0] on_t,
                                             input logic [MS_W-1:0] off_t,
                                             input logic [REPS_W-1:0] reps,
                                             input logic excl);
        lamp_item_t it;
        it.op = op; it.id = id; it.all = all; it.md = md;
        it.on_t = on_t; it.off_t = off_t; it.reps = reps; it.excl = excl;
        it.hold = 1'b0;
        return it;
    endfunction

    function automatic lamp_item_t random_item();
        return make_item(OP_W'($urandom), ID_W'($urandom), 1'($urandom),
                         MODE_W'($urandom), MS_W'($urandom), MS_W'($urandom),
                         REPS_W'($urandom), 1'($urandom));
    endfunction

    function automatic lamp_item_t tick_item();
        lamp_item_t it;
        it = random_item();
        it.op = mlbc_pkg::OP_TICK;
        return it;
    endfunction

    function automatic bit is_ignored(input lamp_item_t it);
        return (it.op != mlbc_pkg::OP_SET && it.op != mlbc_pkg::OP_OFF &&
                it.op != mlbc_pkg::OP_TICK) ||
               (it.op == mlbc_pkg::OP_SET && it.id >= LAMPS) ||
               (it.op == mlbc_pkg::OP_OFF && !it.all && it.id >= LAMPS);
    endfunction

    // driver: bursts of items separated by random gaps
    lamp_item_t cur;
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                predict_item(cur);
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_items.size() == 0)
                begin
                    start <= 1'b0;
                end
                else if (pending_items[0].hold)
                begin
                    // wait here until every queued pattern has come out
                    if (expected_patterns.size() == 0)
                        void'(pending_items.pop_front());
                    start <= 1'b0;
                end
                else
                begin
                    cur = pending_items.pop_front();
                    operation    <= cur.op;
                    lamp_id      <= cur.id;
                    all_lamps    <= cur.all;
                    mode         <= cur.md;
                    on_ms        <= cur.on_t;
                    off_ms       <= cur.off_t;
                    repeat_count <= cur.reps;
                    exclusive    <= cur.excl;
                    start        <= 1'b1;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // monitor: every strobed pattern is checked against the oldest expectation
    always @(posedge clk)
    begin
        logic [LAMPS-1:0] want;
        if (rst_n && result_valid)
        begin
            if (expected_patterns.size() == 0)
            begin
                $display("%0t: display_bits unexpected: expected none, actual %h",
                         $time, display_bits);
                errors++;
            end
            else
            begin
                want = expected_patterns.pop_front();
                if (display_bits !== want)
                begin
                    $display("%0t: display_bits mismatch: expected %h, actual %h",
                             $time, want, display_bits);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with no item taken and no pattern out
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, no progress", $time);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        lamp_item_t it;
        lamp_item_t hold_mark;
        int counted;
        int n;
        int sel;
        for (int k = 0; k < LAMPS; k++)
        begin
            lamp_md[k] = mlbc_pkg::MODE_OFF; lamp_on[k] = 1'b0;
            lit_left[k] = '0; dark_left[k] = '0;
            lit_len[k] = '0; dark_len[k] = '0; blinks_left[k] = '0;
        end
        pattern_now  = '0;
        pattern_sent = '0;
        hold_mark = make_item(mlbc_pkg::OP_TICK, '0, 1'b0, mlbc_pkg::MODE_OFF,
                              '0, '0, '0, 1'b0);
        hold_mark.hold = 1'b1;

        // directed part
        pending_items.push_back(make_item(mlbc_pkg::OP_TICK, 3'd0, 1'b0,
                                          mlbc_pkg::MODE_OFF, 16'd0, 16'd0, 8'd0, 1'b0));
        pending_items.push_back(make_item(mlbc_pkg::OP_SET, 3'd0, 1'b0,
                                          mlbc_pkg::MODE_ON, 16'd0, 16'd0, 8'd0, 1'b0));
        pending_items.push_back(make_item(mlbc_pkg::OP_TICK, 3'd0, 1'b0,
                                          mlbc_pkg::MODE_OFF, 16'd0, 16'd0, 8'd0, 1'b0));
        pending_items.push_back(make_item(mlbc_pkg::OP_SET, 3'd5, 1'b0,
                                          mlbc_pkg::MODE_BLINK, 16'd20, 16'd10, 8'd2,
                                          1'b0));
        for (int k = 0; k < 6; k++) pending_items.push_back(tick_item());
        // lamp ids past the last lamp, unused mode and unused operation
        pending_items.push_back(make_item(mlbc_pkg::OP_SET, 3'd6, 1'b0,
                                          mlbc_pkg::MODE_ON, 16'd0, 16'd0, 8'd0, 1'b1));
        pending_items.push_back(make_item(mlbc_pkg::OP_SET, 3'd7, 1'b1,
                                          mlbc_pkg::MODE_ON, 16'd0, 16'd0, 8'd0, 1'b1));
        pending_items.push_back(make_item(mlbc_pkg::OP_OFF, 3'd7, 1'b0,
                                          mlbc_pkg::MODE_OFF, 16'd0, 16'd0, 8'd0, 1'b0));
        pending_items.push_back(make_item(2'd3, 3'd0, 1'b1, mlbc_pkg::MODE_BLINK,
                                          16'hFFFF, 16'hFFFF, mlbc_pkg::REPS_ENDLESS,
                                          1'b1));
        pending_items.push_back(make_item(mlbc_pkg::OP_SET, 3'd2, 1'b0, 2'd3,
                                          16'hFFFF, 16'hFFFF, mlbc_pkg::REPS_ENDLESS,
                                          1'b0));
        pending_items.push_back(make_item(mlbc_pkg::OP_SET, 3'd3, 1'b0,
                                          mlbc_pkg::MODE_ON, 16'd0, 16'd0, 8'd0, 1'b1));
        pending_items.push_back(tick_item());
        pending_items.push_back(make_item(mlbc_pkg::OP_SET, 3'd4, 1'b0,
                                          mlbc_pkg::MODE_BLINK, 16'hFFFF, 16'd0,
                                          mlbc_pkg::REPS_ENDLESS, 1'b0));
        pending_items.push_back(make_item(mlbc_pkg::OP_SET, 3'd1, 1'b0,
                                          mlbc_pkg::MODE_BLINK, 16'd9, 16'd9, 8'd0, 1'b0));
        pending_items.push_back(tick_item());
        pending_items.push_back(tick_item());
        pending_items.push_back(hold_mark);
        pending_items.push_back(make_item(mlbc_pkg::OP_OFF, 3'd4, 1'b0,
                                          mlbc_pkg::MODE_OFF, 16'd0, 16'd0, 8'd0, 1'b0));
        pending_items.push_back(tick_item());
        pending_items.push_back(make_item(mlbc_pkg::OP_OFF, 3'd0, 1'b1,
                                          mlbc_pkg::MODE_OFF, 16'd0, 16'd0, 8'd0, 1'b0));
        pending_items.push_back(tick_item());

        // random part: mostly set-then-tick sequences
        counted = 0;
        while (counted < RAND_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
            begin
                it = random_item();
                it.op = mlbc_pkg::OP_SET;
                it.id = ID_W'($urandom_range(0, LAMPS - 1));
                case ($urandom_range(0, 7))
                    0:       it.md = mlbc_pkg::MODE_OFF;
                    1, 2:    it.md = mlbc_pkg::MODE_ON;
                    default: it.md = mlbc_pkg::MODE_BLINK;
                endcase
                if ($urandom_range(0, 9) != 0)
                begin
                    it.on_t  = MS_W'($urandom_range(0, 60));
                    it.off_t = MS_W'($urandom_range(0, 60));
                end
                if ($urandom_range(0, 9) != 0)
                    it.reps = ($urandom_range(0, 3) == 0) ? mlbc_pkg::REPS_ENDLESS
                                                          : REPS_W'($urandom_range(0, 6));
                it.excl = ($urandom_range(0, 7) == 0);
                pending_items.push_back(it);
                n = $urandom_range(2, 15);
                for (int k = 0; k < n; k++) pending_items.push_back(tick_item());
                counted += n + 1;
            end
            else if (sel < 70)
            begin
                it = random_item();
                it.op = mlbc_pkg::OP_OFF;
                it.all = ($urandom_range(0, 3) == 0);
                if (!it.all) it.id = ID_W'($urandom_range(0, LAMPS - 1));
                pending_items.push_back(it);
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++) pending_items.push_back(tick_item());
                counted += n + 1;
            end
            else if (sel < 80)
            begin
                n = $urandom_range(1, 30);
                for (int k = 0; k < n; k++) pending_items.push_back(tick_item());
                counted += n;
            end
            else if (sel < 97)
            begin
                it = random_item();
                pending_items.push_back(it);
                if (!is_ignored(it)) counted++;
            end
            else
            begin
                pending_items.push_back(hold_mark);
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || start) @(posedge clk);
        while (expected_patterns.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (expected_patterns.size() != 0)
        begin
            $display("%0t: display_bits missing: expected %h, actual none",
                     $time, expected_patterns[0]);
            errors++;
        end
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
rtl/mlbc_pkg.sv
rtl/mlbc_div.sv
rtl/mlbc_dp.sv
rtl/mlbc_ctrl.sv
rtl/multi_lamp_blink_controller.sv
sim/tb_multi_lamp_blink_controller.sv
